/* design/salc_pkg.sv */
// salc_pkg: shared types, constants and helpers for the set-associative lru cache model
// used by set_assoc_lru_cache_model; no dependencies
`timescale 1ns / 1ps

package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;

  localparam int ADDR_W  = 64;
  localparam int STAMP_W = 32;
  localparam int TOTAL_W = 32;

  // request kinds on the input tuser
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC,
    ST_MASK,
    ST_LOAD,
    ST_RD,
    ST_CMP,
    ST_UPD
  } salc_state_e;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + TOTAL_W'(1);
  endfunction

endpackage

/* design/set_assoc_lru_cache_model.sv */
// set_assoc_lru_cache_model: set-associative cache with lru replacement and hit/miss/evict totals
// depends on salc_pkg and salc_ram (way mask, tag and stamp memories)
//
//   port group   dir  word contents
//   s_axis_*     in   tdata byte_address, tuser req_type
//   m_axis_*     out  tdata hit/evict flags and totals, tlast last_of_item
//   apb          in   set_bits @0x0, block_bits @0x4, ways_in_use @0x8
//
// one lookup: decode, way mask read, then each way in turn through a read state and the shared
// tag/stamp compare (an empty way ends the scan without a compare), then an update state
// load/store compare at most ways_in_use ways (clamped to 1..MAX_WAYS); a modify runs the
// update state twice, once for its load half and once for its store half, giving two result words
// after reset the way mask memory is cleared, one set per cycle
// the update state waits while the previous result word is still held on the output
`timescale 1ns / 1ps

module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // byte_address
  input  logic [1:0]    s_axis_tuser,   // req_type
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // was_hit, was_evicted, hit_total, miss_total, evict_total, zero fill
  output logic [103:0]  m_axis_tdata,
  output logic          m_axis_tlast,   // last_of_item
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  import salc_pkg::*;

  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W    = $clog2(MAX_WAYS + 1);
  localparam int SETS    = 2 ** SET_W;
  localparam int LINES   = 2 ** (SET_W + WAY_W);

  salc_state_e state_q, state_d;

  logic [2:0]          set_bits_q;
  logic [4:0]          block_bits_q;
  logic [3:0]          ways_q;

  logic [SET_W-1:0]    clr_q, clr_d;
  logic                second_q, second_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [SET_W-1:0]    set_q, set_d;
  logic [ADDR_W-1:0]   tag_q, tag_d;
  logic [MAX_WAYS-1:0] mask_q, mask_d;
  logic [WAY_W-1:0]    w_q, w_d;
  logic [WAY_W-1:0]    target_q, target_d;
  logic [WAY_W-1:0]    victim_q, victim_d;
  logic [STAMP_W-1:0]  best_q, best_d;
  logic                hit_q, hit_d;
  logic                evict_q, evict_d;
  logic [STAMP_W-1:0]  clock_q, clock_d;
  logic [TOTAL_W-1:0]  hits_q, hits_d;
  logic [TOTAL_W-1:0]  misses_q, misses_d;
  logic [TOTAL_W-1:0]  evicts_q, evicts_d;
  logic                out_valid_q, out_valid_d;
  logic                out_hit_q, out_hit_d;
  logic                out_evict_q, out_evict_d;
  logic                out_last_q, out_last_d;

  logic [3:0]          sb_eff;
  logic [NW_W-1:0]     nw_eff;
  logic                last_way;
  logic                upd_go;
  logic                new_best;
  logic [ADDR_W-1:0]   set_full;
  logic [ADDR_W-1:0]   set_mask_full;

  logic                mask_we;
  logic [SET_W-1:0]    mask_waddr;
  logic [MAX_WAYS-1:0] mask_wdata;
  logic                mask_re;
  logic [MAX_WAYS-1:0] mask_rdata;
  logic                line_re;
  logic                tag_we;
  logic                stamp_we;
  logic [ADDR_W-1:0]   tag_rdata;
  logic [STAMP_W-1:0]  stamp_rdata;

  // effective geometry
  always_comb begin
    sb_eff = (32'(set_bits_q) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_q};
    if (ways_q == 4'd0) begin
      nw_eff = NW_W'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      nw_eff = NW_W'(MAX_WAYS);
    end else begin
      nw_eff = NW_W'(ways_q);
    end
    last_way      = (32'(w_q) == 32'(nw_eff) - 32'd1);
    set_full      = addr_q >> block_bits_q;
    set_mask_full = (ADDR_W'(1) << sb_eff) - ADDR_W'(1);
    new_best      = (w_q == '0) || (stamp_rdata < best_q);
    upd_go        = !out_valid_q || m_axis_tready;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    second_d    = second_q;
    addr_d      = addr_q;
    set_d       = set_q;
    tag_d       = tag_q;
    mask_d      = mask_q;
    w_d         = w_q;
    target_d    = target_q;
    victim_d    = victim_q;
    best_d      = best_q;
    hit_d       = hit_q;
    evict_d     = evict_q;
    clock_d     = clock_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    evicts_d    = evicts_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_hit_d   = out_hit_q;
    out_evict_d = out_evict_q;
    out_last_d  = out_last_q;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SET_W'(1);
        if (32'(clr_q) == SETS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == REQ_NONE) begin
            clock_d = clock_q + STAMP_W'(1);
          end else begin
            addr_d   = s_axis_tdata;
            second_d = (s_axis_tuser == REQ_MODIFY);
            state_d  = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        set_d   = SET_W'(set_full & set_mask_full);
        tag_d   = addr_q >> (6'(sb_eff) + 6'(block_bits_q));
        state_d = ST_MASK;
      end
      ST_MASK: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        mask_d  = mask_rdata;
        w_d     = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        if (!mask_q[w_q]) begin
          hit_d    = 1'b0;
          evict_d  = 1'b0;
          target_d = w_q;
          state_d  = ST_UPD;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (tag_rdata == tag_q) begin
          hit_d    = 1'b1;
          evict_d  = 1'b0;
          target_d = w_q;
          state_d  = ST_UPD;
        end else begin
          if (new_best) begin
            best_d   = stamp_rdata;
            victim_d = w_q;
          end
          if (last_way) begin
            hit_d    = 1'b0;
            evict_d  = 1'b1;
            target_d = new_best ? w_q : victim_q;
            state_d  = ST_UPD;
          end else begin
            w_d     = w_q + WAY_W'(1);
            state_d = ST_RD;
          end
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          hits_d      = hit_q ? sat_inc(hits_q) : hits_q;
          misses_d    = hit_q ? misses_q : sat_inc(misses_q);
          evicts_d    = evict_q ? sat_inc(evicts_q) : evicts_q;
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_evict_d = evict_q;
          out_last_d  = !second_q;
          if (second_q) begin
            // store half of a modify hits the line just touched
            second_d = 1'b0;
            hit_d    = 1'b1;
            evict_d  = 1'b0;
          end else begin
            clock_d = clock_q + STAMP_W'(1);
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      second_q    <= 1'b0;
      clock_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      second_q    <= second_d;
      clock_q     <= clock_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      evicts_q    <= evicts_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    set_q       <= set_d;
    tag_q       <= tag_d;
    mask_q      <= mask_d;
    w_q         <= w_d;
    target_q    <= target_d;
    victim_q    <= victim_d;
    best_q      <= best_d;
    hit_q       <= hit_d;
    evict_q     <= evict_d;
    out_hit_q   <= out_hit_d;
    out_evict_q <= out_evict_d;
    out_last_q  <= out_last_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd0;
      block_bits_q <= 5'd4;
      ways_q       <= 4'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_SET_BITS:   set_bits_q   <= pwdata[2:0];
        REG_BLOCK_BITS: block_bits_q <= pwdata[4:0];
        REG_WAYS:       ways_q       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS:   prdata = {29'd0, set_bits_q};
      REG_BLOCK_BITS: prdata = {27'd0, block_bits_q};
      REG_WAYS:       prdata = {28'd0, ways_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  // memories
  assign mask_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPD) && upd_go);
  assign mask_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;
  assign mask_wdata = (state_q == ST_CLEAR) ? '0 : (mask_q | (MAX_WAYS'(1) << target_q));
  assign mask_re    = (state_q == ST_MASK);
  assign line_re    = (state_q == ST_RD) && mask_q[w_q];
  assign tag_we     = (state_q == ST_UPD) && upd_go && !hit_q;
  assign stamp_we   = (state_q == ST_UPD) && upd_go;

  salc_ram #(
    .WIDTH (MAX_WAYS),
    .DEPTH (SETS)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (mask_we),
    .waddr_i (mask_waddr),
    .wdata_i (mask_wdata),
    .re_i    (mask_re),
    .raddr_i (set_q),
    .rdata_o (mask_rdata)
  );

  salc_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (LINES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i ({set_q, target_q}),
    .wdata_i (tag_q),
    .re_i    (line_re),
    .raddr_i ({set_q, w_q}),
    .rdata_o (tag_rdata)
  );

  salc_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (LINES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i ({set_q, target_q}),
    .wdata_i (clock_q),
    .re_i    (line_re),
    .raddr_i ({set_q, w_q}),
    .rdata_o (stamp_rdata)
  );

  // result word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'd0, evicts_q, misses_q, hits_q, out_evict_q, out_hit_q};

`ifndef SYNTHESIS
  a_hit_excl_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("hit and eviction reported together");

  a_modify_second_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && upd_go && second_q) |=> (hit_q && !evict_q))
    else $error("second lookup of a modify is not a hit");

  a_way_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD || state_q == ST_CMP) |-> (32'(w_q) < 32'(nw_eff)))
    else $error("way counter beyond associativity");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input taken during mask clear");
`endif

endmodule

/* design/salc_ram.sv */
// salc_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/sv/set_assoc_lru_cache_model_test.sv */
// set_assoc_lru_cache_model_test: self-checking bench for the set-associative lru cache model
// drives load/store/modify words and apb geometry writes, predicts every lookup word
// depends on salc_pkg and set_assoc_lru_cache_model
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_test;
  import salc_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int          RESET_CYCLES  = 7;
  localparam int          NUM_SETS      = 1 << MAX_SET_BITS_DEF;
  localparam int          SETTLE_CYCLES = NUM_SETS + 40;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          PHASE_ITEMS   = 114;
  localparam logic [1:0]  REQ_LOAD      = 2'd0;
  localparam logic [1:0]  REQ_STORE     = 2'd1;

  typedef struct {
    bit            hit;
    bit            evict;
    bit            last;
    bit [31:0]     hits;
    bit [31:0]     misses;
    bit [31:0]     evicts;
  } lookup_word_t;

  class lookup_scoreboard;
    bit             way_valid [NUM_SETS][MAX_WAYS_DEF];
    bit [63:0]      way_tag   [NUM_SETS][MAX_WAYS_DEF];
    bit [31:0]      way_stamp [NUM_SETS][MAX_WAYS_DEF];
    bit [31:0]      request_clock;
    bit [31:0]      hit_tally;
    bit [31:0]      miss_tally;
    bit [31:0]      evict_count;
    bit [2:0]       cfg_set_bits   = 3'd0;
    bit [4:0]       cfg_block_bits = 5'd4;
    bit [3:0]       cfg_ways       = 4'd1;
    lookup_word_t   expected_lookups [$];
    int unsigned    failures;

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_SET_BITS:   cfg_set_bits   = value[2:0];
        REG_BLOCK_BITS: cfg_block_bits = value[4:0];
        REG_WAYS:       cfg_ways       = value[3:0];
        default: ;
      endcase
    endfunction

    function void predict_lookup(bit [63:0] addr, bit last);
      int unsigned  sb;
      int unsigned  nw;
      int unsigned  set_idx;
      int unsigned  way;
      int unsigned  victim;
      int unsigned  i;
      bit [63:0]    tag;
      bit           hit;
      bit           evict;
      lookup_word_t w;
      sb = (cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cfg_set_bits;
      nw = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : cfg_ways);
      set_idx = int'((addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1));
      tag = addr >> (sb + cfg_block_bits);
      hit = 1'b0;
      evict = 1'b0;
      way = nw;
      for (i = 0; i < nw; i++) begin
        if (way == nw) begin
          if (!way_valid[set_idx][i]) begin
            way = i;
          end else if (way_tag[set_idx][i] == tag) begin
            way = i;
            hit = 1'b1;
          end
        end
      end
      if (hit) begin
        if (hit_tally != '1) hit_tally++;
      end else begin
        if (miss_tally != '1) miss_tally++;
        if (way == nw) begin
          victim = 0;
          for (i = 1; i < nw; i++) begin
            if (way_stamp[set_idx][i] < way_stamp[set_idx][victim]) victim = i;
          end
          way = victim;
          evict = 1'b1;
          if (evict_count != '1) evict_count++;
        end
        way_valid[set_idx][way] = 1'b1;
        way_tag[set_idx][way] = tag;
      end
      way_stamp[set_idx][way] = request_clock;
      w.hit = hit;
      w.evict = evict;
      w.last = last;
      w.hits = hit_tally;
      w.misses = miss_tally;
      w.evicts = evict_count;
      expected_lookups.push_back(w);
    endfunction

    function void note_request(logic [1:0] kind, logic [63:0] addr);
      if (kind == REQ_LOAD || kind == REQ_STORE) begin
        predict_lookup(addr, 1'b1);
      end else if (kind == REQ_MODIFY) begin
        predict_lookup(addr, 1'b0);
        predict_lookup(addr, 1'b1);
      end
      request_clock++;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_lookup(logic [103:0] data, logic last);
      lookup_word_t want;
      if (expected_lookups.size() == 0) begin
        note_failure($sformatf("result word with nothing pending: %h last %b", data, last));
        return;
      end
      want = expected_lookups.pop_front();
      if (data[0] !== want.hit || data[1] !== want.evict || last !== want.last ||
          data[33:2] !== want.hits || data[65:34] !== want.misses ||
          data[97:66] !== want.evicts) begin
        note_failure($sformatf({"lookup mismatch: expected hit %0d evict %0d last %0d ",
                                "totals %0d %0d %0d, got hit %b evict %b last %b ",
                                "totals %0d %0d %0d"},
                               want.hit, want.evict, want.last,
                               want.hits, want.misses, want.evicts,
                               data[0], data[1], last, data[33:2], data[65:34], data[97:66]));
      end
    endfunction

    function int unsigned pending();
      return expected_lookups.size();
    endfunction
  endclass

  logic           clk_i         = 1'b0;
  logic           rst_ni        = 1'b0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [63:0]    s_axis_tdata  = '0;   // byte_address
  logic [1:0]     s_axis_tuser  = '0;   // req_type
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  // was_hit, was_evicted, hit_total, miss_total, evict_total, zero fill
  logic [103:0]   m_axis_tdata;
  logic           m_axis_tlast;         // last_of_item
  logic           psel          = 1'b0;
  logic           penable       = 1'b0;
  logic           pwrite        = 1'b0;
  logic [3:0]     paddr         = '0;
  logic [31:0]    pwdata        = '0;
  logic [31:0]    prdata;
  logic           pready;

  bit               calm;
  int unsigned      cycle_count;
  lookup_scoreboard board = new();

  set_assoc_lru_cache_model dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("set_assoc_lru_cache_model_test failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_lookup(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic send_word(input logic [1:0] kind, input logic [63:0] addr);
    while (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(kind, addr);
  endtask

  // stop sending, wait out every pending word and any work still in flight
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, value);
  endtask

  task automatic set_geometry(input int unsigned sbits, input int unsigned bbits,
                              input int unsigned ways);
    wait_drained();
    apb_write(REG_SET_BITS, 32'(sbits));
    apb_write(REG_BLOCK_BITS, 32'(bbits));
    apb_write(REG_WAYS, 32'(ways));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly words from a small tag pool in a few hot sets, so hits and evictions stay frequent
  task automatic run_phase(input int unsigned sbits, input int unsigned bbits,
                           input int unsigned ways, input int unsigned count);
    logic [63:0]  tag_pool [10];
    logic [63:0]  addr;
    logic [63:0]  set_sel;
    logic [63:0]  set_mask;
    logic [63:0]  off_mask;
    logic [1:0]   kind;
    int unsigned  sb;
    int unsigned  pool_n;
    int unsigned  n;
    int unsigned  r;
    set_geometry(sbits, bbits, ways);
    sb = (sbits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : sbits;
    pool_n = ((ways == 0) ? 1 : ((ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : ways)) + 2;
    set_mask = (64'd1 << sb) - 64'd1;
    off_mask = (64'd1 << bbits) - 64'd1;
    foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 8) begin
        addr = {$urandom, $urandom};
      end else begin
        set_sel = ($urandom_range(99) < 80) ? 64'($urandom_range(3)) : 64'($urandom);
        addr = (tag_pool[$urandom_range(pool_n - 1)] << (sb + bbits))
             | ((set_sel & set_mask) << bbits)
             | ({$urandom, $urandom} & off_mask);
      end
      r = $urandom_range(99);
      if (r < 30)      kind = REQ_LOAD;
      else if (r < 60) kind = REQ_STORE;
      else if (r < 94) kind = REQ_MODIFY;
      else             kind = REQ_NONE;
      send_word(kind, addr);
    end
  endtask

  initial begin
    int unsigned t;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: one set, 16-byte blocks, direct mapped
    send_word(REQ_LOAD, 64'h0);
    send_word(REQ_LOAD, 64'hF);
    send_word(REQ_STORE, 64'h10);
    send_word(REQ_MODIFY, 64'h10);
    send_word(REQ_MODIFY, '1);
    send_word(REQ_NONE, 64'h0);
    send_word(REQ_LOAD, 64'h0);

    // fill one 4-way set, then check the least recently used line goes first
    set_geometry(2, 4, 4);
    for (t = 1; t <= 4; t++) send_word(t[0] ? REQ_LOAD : REQ_STORE, (64'(t) << 6) | 64'h10);
    send_word(REQ_LOAD, 64'h50);
    send_word(REQ_STORE, 64'h150);
    send_word(REQ_LOAD, 64'h90);
    send_word(REQ_MODIFY, 64'h50);

    // oversized set field, widest offset, zero ways
    set_geometry(7, 31, 0);
    send_word(REQ_LOAD, '1);
    send_word(REQ_STORE, 64'h0);
    send_word(REQ_MODIFY, 64'h8000_0000_0000_0000);

    // way count above the maximum, nine tags into one set
    set_geometry(6, 0, 15);
    for (t = 0; t < 9; t++) send_word(REQ_LOAD, 64'(t) << 6);

    calm = 1'b1;
    run_phase(2, 4, 4, PHASE_ITEMS);
    calm = 1'b0;
    run_phase(0, 0, 1, PHASE_ITEMS);
    run_phase(6, 26, 8, PHASE_ITEMS);
    run_phase(7, 31, 15, PHASE_ITEMS);
    run_phase(3, 5, 0, PHASE_ITEMS);
    run_phase(1, 6, 2, PHASE_ITEMS);
    run_phase($urandom_range(7), $urandom_range(31), $urandom_range(15), PHASE_ITEMS);
    run_phase($urandom_range(7), $urandom_range(31), $urandom_range(15), PHASE_ITEMS);
    run_phase($urandom_range(7), $urandom_range(31), $urandom_range(15), PHASE_ITEMS);

    wait_drained();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("set_assoc_lru_cache_model_test passed");
    end else begin
      $display("set_assoc_lru_cache_model_test failed");
    end
    $finish;
  end

endmodule
